>>> rtl/bitmap_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_macros.svh
// Assertion shorthands for the slot allocator checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// checked only outside reset
`define BSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked during reset as well
`define BSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Field widths, request kinds and result codes of the slot allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int POOL_W   = 11;
  localparam int STATUS_W = 2;

  // slot count, tied to the slot and pool field widths
  localparam int SLOTS    = 1024;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd3;

endpackage : bsa_pkg

`default_nettype wire

>>> rtl/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual-port RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bsa_ram

`default_nettype wire

>>> rtl/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit free-slot allocator over a word-organised availability bitmap.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall with a kind (allocate, release, set
// cancel flag), a slot and a cancel value; each request yields one result on
// out_valid/out_stall with a granted slot and a status.
// The bitmap sits in a RAM of WORDS words; one scan unit (word counter, base
// adder and a subtract/compare) walks it one word per cycle.
// States a request passes, from its acceptance to the next acceptance:
//   allocate : S_ACHK for each word scanned up to the first free one
//              (at most WORDS), then S_DONE
//   release  : S_RFIND up to the slot's word, S_RCHK, S_DONE; bad slots S_DONE
//   cancel   : S_DONE
// The result shows on out_valid in the same cycle that in_stall drops for the next request.
// The next request is taken once the previous result sits in the output
// register, so a stalled receiver holds one finished result and the block
// still takes one more request, then waits to deliver it.
// Reset and every pool size write rebuild the bitmap in a pass over all WORDS
// words (one word a cycle) with in_stall high; a pool size write also
// clears the cancel flag. Reset drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator #(
  parameter int WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bsa_pkg::KIND_W-1:0]     in_kind,
  input  logic [bsa_pkg::SLOT_W-1:0]     in_slot,
  input  logic                           in_cancel_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bsa_pkg::SLOT_W-1:0]     out_granted_slot,
  output logic [bsa_pkg::STATUS_W-1:0]   out_status,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [bsa_pkg::POOL_W-1:0]     cfg_wr_data
);

  import bsa_pkg::*;

  localparam int WORDS  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int BASE_W = $clog2(WORDS * WORD_BITS) + 1;
  localparam int CMP_W  = ((BASE_W > POOL_W) ? BASE_W : POOL_W) + 1;
  localparam int SUM_W  = (BASE_W > SLOT_W) ? BASE_W : SLOT_W;

  typedef enum logic [5:0] {
    S_FILL  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ACHK  = 6'b000100,
    S_RFIND = 6'b001000,
    S_RCHK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [WIDX_W-1:0]     w_r, w_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic [POOL_W-1:0]     pool_r, pool_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  cancelled_r, cancelled_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  ram_we;
  logic [WIDX_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

  logic                  last_word;
  logic [CMP_W-1:0]      diff;
  logic                  diff_neg, diff_ge_wb;
  logic [WORD_BITS-1:0]  fill_word;
  logic [WORD_BITS-1:0]  low_bit;
  logic [BIT_W-1:0]      low_idx;
  logic [SUM_W-1:0]      grant_sum;
  logic                  accept, deliver;

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS),
    .AW    (WIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- shared scan datapath ----
  assign last_word = (w_r == WIDX_W'(WORDS - 1));

  // distance from the current word base to the pool end (fill) or slot (release)
  assign diff       = ((state_r == S_FILL) ? CMP_W'(pool_r) : CMP_W'(slot_r))
                      - CMP_W'(base_r);
  assign diff_neg   = diff[CMP_W-1];
  assign diff_ge_wb = !diff_neg && (diff >= CMP_W'(WORD_BITS));

  always_comb begin
    if (diff_neg) begin
      fill_word = '0;
    end else if (diff_ge_wb) begin
      fill_word = '1;
    end else begin
      fill_word = ~({WORD_BITS{1'b1}} << diff[BIT_W-1:0]);
    end
  end

  // lowest set bit isolated, then encoded by an OR over the one-hot word
  assign low_bit = ram_rdata & (~ram_rdata + WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | BIT_W'(i);
      end
    end
  end

  assign grant_sum = SUM_W'(base_r) + SUM_W'(low_idx);

  // ---- handshakes ----
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign deliver  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // ---- sequencer ----
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    base_nxt       = base_r;
    bit_nxt        = bit_r;
    pool_nxt       = pool_r;
    slot_nxt       = slot_r;
    cancelled_nxt  = cancelled_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = fill_word;
    ram_raddr      = w_r;

    unique case (state_r)
      S_FILL: begin
        ram_we = 1'b1;
        if (last_word) begin
          state_nxt = S_IDLE;
        end else begin
          w_nxt    = w_r + WIDX_W'(1);
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end
      end

      S_IDLE: begin
        ram_raddr = '0;
        if (accept) begin
          w_nxt          = '0;
          base_nxt       = '0;
          slot_nxt       = in_slot;
          res_slot_nxt   = '0;
          res_status_nxt = ST_OK;
          unique case (in_kind)
            KIND_ALLOC: begin
              if (cancelled_r) begin
                res_status_nxt = ST_CANCELLED;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_ACHK;
              end
            end
            KIND_RELEASE: begin
              if (POOL_W'(in_slot) >= pool_r) begin
                res_status_nxt = ST_BAD_RELEASE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RFIND;
              end
            end
            KIND_CANCEL: begin
              cancelled_nxt = in_cancel_value;
              state_nxt     = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ACHK: begin
        // next word is fetched while this one is checked
        ram_raddr = last_word ? w_r : (w_r + WIDX_W'(1));
        if (ram_rdata != '0) begin
          ram_we         = 1'b1;
          ram_wdata      = ram_rdata & ~low_bit;
          res_slot_nxt   = grant_sum[SLOT_W-1:0];
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
        end else if (last_word) begin
          res_status_nxt = ST_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          w_nxt    = w_r + WIDX_W'(1);
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end
      end

      S_RFIND: begin
        if (!diff_ge_wb) begin
          bit_nxt   = diff[BIT_W-1:0];
          state_nxt = S_RCHK;
        end else begin
          w_nxt    = w_r + WIDX_W'(1);
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end
      end

      S_RCHK: begin
        if (ram_rdata[bit_r]) begin
          res_status_nxt = ST_BAD_RELEASE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_r);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (deliver) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_FILL;
      end
    endcase

    // pool size write restarts the rebuild pass
    if (cfg_wr_en) begin
      pool_nxt      = (32'(cfg_wr_data) > SLOTS) ? POOL_W'(SLOTS) : cfg_wr_data;
      cancelled_nxt = 1'b0;
      state_nxt     = S_FILL;
      w_nxt         = '0;
      base_nxt      = '0;
    end
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    if (deliver) begin
      out_valid_nxt  = 1'b1;
      out_slot_nxt   = res_slot_r;
      out_status_nxt = res_status_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      w_r         <= '0;
      base_r      <= '0;
      pool_r      <= '0;
      cancelled_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      base_r      <= base_nxt;
      pool_r      <= pool_nxt;
      cancelled_r <= cancelled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r        <= bit_nxt;
    slot_r       <= slot_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

endmodule : bitmap_slot_allocator

`default_nettype wire

>>> rtl/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_slot_allocator_macros.svh"

module bsa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bsa_pkg::SLOT_W-1:0]   out_granted_slot,
  input logic [bsa_pkg::STATUS_W-1:0] out_status,
  input logic                         cfg_wr_en
);

  import bsa_pkg::*;

  // a held result keeps its payload
  `BSA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_granted_slot) && $stable(out_status), "result changed while stalled")

  // only a successful allocate carries a slot number
  `BSA_ASSERT(a_slot_zero, out_valid && (out_status != ST_OK) |-> out_granted_slot == '0, "slot set on a failed request")

  // bitmap rebuild blocks requests after reset and after a pool size write
  `BSA_ASSERT_ALWAYS(a_reset_fill, !rst_n |=> in_stall && !out_valid, "requests open straight after reset")
  `BSA_ASSERT(a_cfg_fill, cfg_wr_en |=> in_stall, "requests open during rebuild")

endmodule : bsa_checker

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

`default_nettype wire

>>> tb/sv/bitmap_slot_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_checker
// Watches the request, result and pool size ports of the slot allocator,
// keeps its own copy of the free map and cancel flag, and compares every
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bsa_pkg::KIND_W-1:0]    in_kind,
  input  logic [bsa_pkg::SLOT_W-1:0]    in_slot,
  input  logic                          in_cancel_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bsa_pkg::SLOT_W-1:0]    out_granted_slot,
  input  logic [bsa_pkg::STATUS_W-1:0]  out_status,
  input  logic                          cfg_wr_en,
  input  logic [bsa_pkg::POOL_W-1:0]    cfg_wr_data,
  output int                            mismatch_count,
  output int                            results_due
);
  import bsa_pkg::*;

  localparam int SLOT_COUNT = 1 << SLOT_W;

  typedef struct packed {
    logic [SLOT_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic [SLOT_COUNT-1:0] free_map;
  logic                  cancel_flag;
  logic [POOL_W-1:0]     pool_limit;
  grant_t                grants_due[$];

  function automatic void load_pool(input logic [POOL_W-1:0] size);
    pool_limit = (size > SLOT_COUNT) ? POOL_W'(SLOT_COUNT) : size;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      free_map[i] = (i < pool_limit);
    end
    cancel_flag = 1'b0;
  endfunction

  // first fit: lowest free slot wins
  function automatic grant_t serve_request(input logic [KIND_W-1:0] kind,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic cancel_value);
    grant_t res;
    bit     found;
    res = '{granted: '0, status: ST_OK};
    found = 0;
    case (kind)
      KIND_ALLOC: begin
        if (cancel_flag) begin
          res.status = ST_CANCELLED;
        end else begin
          for (int i = 0; i < SLOT_COUNT && !found; i++) begin
            if (free_map[i]) begin
              free_map[i] = 1'b0;
              res.granted = SLOT_W'(i);
              found = 1;
            end
          end
          if (!found) res.status = ST_EMPTY;
        end
      end
      KIND_RELEASE: begin
        if (POOL_W'(slot) >= pool_limit || free_map[slot]) begin
          res.status = ST_BAD_RELEASE;
        end else begin
          free_map[slot] = 1'b1;
        end
      end
      KIND_CANCEL: begin
        cancel_flag = cancel_value;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      load_pool('0);
      grants_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) load_pool(cfg_wr_data);
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected result: slot %0d status %0d", $time,
                   out_granted_slot, out_status);
          mismatch_count++;
        end else begin
          want = grants_due.pop_front();
          if (out_granted_slot !== want.granted) begin
            $display("%0t: granted slot mismatch: expected %0d, got %0d", $time,
                     want.granted, out_granted_slot);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time,
                     want.status, out_status);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        grants_due.push_back(serve_request(in_kind, in_slot, in_cancel_value));
      end
    end
    results_due = grants_due.size();
  end

endmodule

>>> tb/sv/bitmap_slot_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_test
// Drives allocate, release and cancel requests into the slot allocator over
// a range of pool sizes, with bursty requests and a stalling receiver, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_test;
  import bsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SLOT_COUNT    = 1 << SLOT_W;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 500;
  localparam int WATCHDOG      = 3000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_cancel_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [SLOT_W-1:0]    out_granted_slot;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_wr_en;
  logic [POOL_W-1:0]    cfg_wr_data;

  int mismatch_count;
  int results_due;
  int requests_taken;
  int quiet_cycles;
  int burst_left;

  bitmap_slot_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_cancel_value  (in_cancel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  bitmap_slot_allocator_checker alloc_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_slot          (in_slot),
    .in_cancel_value  (in_cancel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .results_due      (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any handshake or pool write counts as progress
  always @(posedge clk) begin
    if (!rst_n) begin
      requests_taken = 0;
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) requests_taken++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at a falling edge once accepted
  task automatic push_request(input logic [KIND_W-1:0] kind,
                              input logic [SLOT_W-1:0] slot,
                              input logic cancel_value);
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_slot         <= slot;
    in_cancel_value <= cancel_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_pool(input logic [POOL_W-1:0] size);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : request_side
    logic [POOL_W-1:0] pool_corners[10];
    logic [POOL_W-1:0] pool_sel;
    int                usable;
    int                sent;
    int                phase;
    int                len;
    int                alloc_pct;
    int                pick;

    pool_corners = '{0, 1, 63, 64, 65, 127, 1023, 1024, 1025, 2047};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_ALLOC;
    in_slot         = '0;
    in_cancel_value = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    burst_left      = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pool straight out of reset
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd1023, 1'b1);
    push_request(KIND_UNUSED, 10'd1023, 1'b1);
    push_request(KIND_CANCEL, 10'd0, 1'b1);
    push_request(KIND_ALLOC, 10'd1023, 1'b0);
    push_request(KIND_RELEASE, 10'd0, 1'b0);
    push_request(KIND_CANCEL, 10'd1023, 1'b0);

    // oversized pool saturates to the full slot count
    settle();
    write_pool(11'd2047);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd0, 1'b0);       // already free
    push_request(KIND_RELEASE, 10'd1023, 1'b0);    // top slot, never taken
    push_request(KIND_CANCEL, 10'd0, 1'b1);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd1, 1'b0);       // release still works
    push_request(KIND_CANCEL, 10'd0, 1'b0);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_CANCEL, 10'd0, 1'b1);

    // pool write must drop the cancel flag
    settle();
    write_pool(11'd1);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_ALLOC, 10'd0, 1'b0);
    push_request(KIND_RELEASE, 10'd1, 1'b0);       // beyond the pool
    push_request(KIND_RELEASE, 10'd0, 1'b0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        // long allocate-heavy run on the full pool to reach the upper words
        pool_sel = 11'd1024;
        len = 450;
        alloc_pct = 85;
      end else begin
        pool_sel = ($urandom_range(0, 3) == 0) ? pool_corners[$urandom_range(0, 9)]
                                               : POOL_W'($urandom_range(1, 150));
        len = $urandom_range(40, 120);
        alloc_pct = $urandom_range(35, 60);
      end
      usable = (pool_sel > SLOT_COUNT) ? SLOT_COUNT : pool_sel;
      settle();
      write_pool(pool_sel);
      for (int n = 0; n < len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
          push_request(KIND_ALLOC, SLOT_W'($urandom), 1'($urandom));
        else if (pick < 90)
          push_request(KIND_RELEASE,
                       (usable == 0) ? SLOT_W'($urandom)
                                     : SLOT_W'($urandom_range(0, usable - 1)),
                       1'($urandom));
        else if (pick < 94)
          push_request(KIND_RELEASE, SLOT_W'($urandom), 1'($urandom));
        else if (pick < 98)
          push_request(KIND_CANCEL, SLOT_W'($urandom), $urandom_range(0, 3) == 0);
        else
          push_request(KIND_UNUSED, SLOT_W'($urandom), 1'($urandom));
      end
      sent += len;
      phase++;
    end

    settle();
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : result_side
    int  mode;
    int  span;
    bit  held;

    out_stall = 1'b0;
    held = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      while (span > 0) begin
        @(negedge clk);
        if (!held && requests_taken >= 300) begin
          // long back-pressure while requests keep coming
          held = 1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          out_stall <= 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= ($urandom_range(0, 99) < 85);
            default: out_stall <= (span % 3 == 0);
          endcase
        end
        span--;
      end
    end
  end

endmodule

>>> bitmap_slot_allocator.f
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_ram.sv
rtl/bitmap_slot_allocator.sv
rtl/bsa_checker.sv
tb/sv/bitmap_slot_allocator_checker.sv
tb/sv/bitmap_slot_allocator_test.sv
